// File: src/s2da_pkg.sv
// shared types, constants and the double-dabble step for the integer to decimal text converter
`timescale 1ns / 1ps

package s2da_pkg;

   localparam int VALUE_W         = 32;
   localparam int DIGITS          = 10;
   localparam int DIGIT_W         = 4;
   localparam int BCD_W           = DIGITS * DIGIT_W;
   localparam int IDX_W           = $clog2(DIGITS);
   localparam int CHAR_W          = 7;
   localparam int STEPS_PER_STAGE = 4;
   localparam int STAGES          = VALUE_W / STEPS_PER_STAGE;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;

   // word in flight through the conversion pipeline
   typedef struct packed {
      logic               neg;
      logic [BCD_W-1:0]   bcd;
      logic [VALUE_W-1:0] bin;
   } s2da_work_type;

   // one shift-and-add-3 step
   function automatic s2da_work_type s2da_dabble(input s2da_work_type w);
      logic [BCD_W-1:0] b;
      s2da_work_type    r;
      b = w.bcd;
      for (int d = 0; d < DIGITS; d++) begin
         if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
         end
      end
      r.neg = w.neg;
      r.bcd = {b[BCD_W-2:0], w.bin[VALUE_W-1]};
      r.bin = {w.bin[VALUE_W-2:0], 1'b0};
      return r;
   endfunction

   // index of the most significant nonzero digit, zero when all digits are zero
   function automatic logic [IDX_W-1:0] s2da_top_digit(input logic [BCD_W-1:0] b);
      logic [IDX_W-1:0] top;
      top = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (b[d*DIGIT_W +: DIGIT_W] != 4'd0) begin
            top = IDX_W'(d);
         end
      end
      return top;
   endfunction

endpackage

// File: src/signed_int_to_decimal_ascii_top.sv
// top level: signed 32-bit integer to decimal ascii text
`timescale 1ns / 1ps

// usage
//   input: drive req_value and raise start; the word is taken at a rising edge
//   where start is high and busy is low
//   output: each character shows on rsp_character for one cycle with
//   rsp_strobe high; rsp_last marks the final character of a number
//   text is most significant first, a leading '-' for negative values,
//   no leading zeros, zero gives a single '0'
// path
//   a word passes through the entry register (sign and magnitude) at the
//   taking edge, eight shift-and-add-3 stages of four bit steps, the serializer
//   load register and the output register, which drives the first character
// throughput
//   the serializer emits one character per cycle and a text runs 1 to 11 characters;
//   the pipeline holds up to nine words behind it and busy rises only once the
//   whole pipeline is backed up
// reset
//   synchronous, active high; clears every valid bit and the strobe, so
//   words in flight are dropped
// stalls
//   the receiver cannot stall; characters of one number come back to back

module signed_int_to_decimal_ascii_top
   import s2da_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_strobe,
   output logic [CHAR_W-1:0]         rsp_character,
   output logic                      rsp_last
);

   // entry register: sign and unsigned magnitude
   logic          entry_valid_ff, entry_valid_in;
   s2da_work_type entry_data_ff, entry_data_in;
   logic          entry_ready;
   logic          accept;

   // pipeline links, index i feeds stage i, the last index feeds the serializer
   logic          stg_valid [0:STAGES];
   s2da_work_type stg_data  [0:STAGES];
   logic          stg_ready [0:STAGES];

   assign entry_ready = !entry_valid_ff || stg_ready[0];
   assign busy        = !entry_ready;
   assign accept      = start && entry_ready;

   always_comb begin
      entry_valid_in = entry_ready ? start : entry_valid_ff;
      entry_data_in  = entry_data_ff;
      if (accept) begin
         entry_data_in.neg = req_value[VALUE_W-1];
         // the most negative value negates to itself, which is its magnitude
         entry_data_in.bin = req_value[VALUE_W-1] ? (~req_value + 1'b1) : req_value;
         entry_data_in.bcd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_data_ff <= entry_data_in;
   end

   assign stg_valid[0] = entry_valid_ff;
   assign stg_data[0]  = entry_data_ff;

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      s2da_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[g]),
         .in_data   (stg_data[g]),
         .in_ready  (stg_ready[g]),
         .out_valid (stg_valid[g+1]),
         .out_data  (stg_data[g+1]),
         .out_ready (stg_ready[g+1])
      );
   end

   s2da_serializer u_ser (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (stg_valid[STAGES]),
      .in_data       (stg_data[STAGES]),
      .in_ready      (stg_ready[STAGES]),
      .out_strobe    (rsp_strobe),
      .out_character (rsp_character),
      .out_last      (rsp_last)
   );

`ifndef ASSERT_OFF
   // a taken word always lands in the entry register
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> entry_valid_ff)
      else $error("accepted word not captured");

   // characters of one number are never split by a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside a number's text");

   // a minus sign is always followed by a digit
   a_minus_then_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_character == CHAR_MINUS)
         |=> (rsp_strobe && rsp_character != CHAR_MINUS))
      else $error("minus sign not followed by a digit");

   // only minus or decimal digits come out
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_character == CHAR_MINUS && !rsp_last) ||
                      (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE)))
      else $error("bad character");
`endif

endmodule

// File: src/s2da_dabble_stage.sv
// one pipeline stage of the binary to bcd conversion
`timescale 1ns / 1ps

module s2da_dabble_stage
   import s2da_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  s2da_work_type in_data,
   output logic          in_ready,
   output logic          out_valid,
   output s2da_work_type out_data,
   input  logic          out_ready
);

   logic          valid_ff;
   logic          valid_in;
   s2da_work_type data_ff;
   s2da_work_type data_in;
   s2da_work_type stepped;

   always_comb begin
      stepped = in_data;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         stepped = s2da_dabble(stepped);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign data_in  = (in_ready && in_valid) ? stepped : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: src/s2da_serializer.sv
// turns a converted word into one ascii character per cycle
`timescale 1ns / 1ps

module s2da_serializer
   import s2da_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  s2da_work_type     in_data,
   output logic              in_ready,
   output logic              out_strobe,
   output logic [CHAR_W-1:0] out_character,
   output logic              out_last
);

   logic                           active_ff, active_in;
   logic                           minus_ff, minus_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [DIGITS-1:0][DIGIT_W-1:0] bcd_ff, bcd_in;
   logic                           strobe_ff, strobe_in;
   logic [CHAR_W-1:0]              char_ff, char_in;
   logic                           last_ff, last_in;
   logic                           load;

   // free on the final digit so the next word loads without a gap
   assign in_ready = !active_ff || (!minus_ff && idx_ff == '0);
   assign load     = in_valid && in_ready;

   always_comb begin
      active_in = active_ff;
      minus_in  = minus_ff;
      idx_in    = idx_ff;
      bcd_in    = bcd_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      if (active_ff) begin
         strobe_in = 1'b1;
         if (minus_ff) begin
            char_in  = CHAR_MINUS;
            last_in  = 1'b0;
            minus_in = 1'b0;
         end else begin
            char_in = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd_ff[idx_ff]};
            last_in = (idx_ff == '0);
            if (idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               active_in = 1'b0;
            end
         end
      end
      if (load) begin
         active_in = 1'b1;
         minus_in  = in_data.neg;
         idx_in    = s2da_top_digit(in_data.bcd);
         bcd_in    = in_data.bcd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      minus_ff <= minus_in;
      idx_ff   <= idx_in;
      bcd_ff   <= bcd_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign out_strobe    = strobe_ff;
   assign out_character = char_ff;
   assign out_last      = last_ff;

endmodule

// File: dv/testbench.sv
// testbench for the signed integer to decimal ascii converter
`timescale 1ns / 1ps

module testbench;
   import s2da_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 10;
   localparam int STALL_LIMIT   = 1000;  // cycles with neither a word taken nor a character seen
   localparam int SETTLE_CYCLES = 30;    // covers the pipeline latency with room to spare
   localparam int MAX_REPORTS   = 30;
   localparam int DEC_BASE      = 10;
   localparam int RANDOM_WORDS  = 100;   // per random phase

   localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

   // one character of the expected text
   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      busy;
   logic                      rsp_strobe;
   logic [CHAR_W-1:0]         rsp_character;
   logic                      rsp_last;

   // characters still owed by the block, oldest first
   text_char_type expected_text[$];

   int error_count       = 0;
   int words_sent        = 0;
   int chars_checked     = 0;
   int negative_words    = 0;
   int full_length_words = 0;
   int idle_pct          = 0;   // chance in a hundred that the sender idles a cycle
   int stall_cycles      = 0;

   always #HALF_PERIOD clock = ~clock;

   signed_int_to_decimal_ascii_top uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // expected decimal text of one word, appended to the expected queue
   function automatic void spell_decimal(input logic [VALUE_W-1:0] bits);
      logic             neg;
      logic [VALUE_W-1:0] mag;
      logic [3:0]       digit_list[DIGITS];
      int               count;
      text_char_type    ch;
      neg   = bits[VALUE_W-1];
      // two's complement negate; the most negative value maps to its own unsigned magnitude
      mag   = neg ? (~bits + 1'b1) : bits;
      count = 0;
      // digits least significant first, zero still gives one digit
      do begin
         digit_list[count] = 4'(mag % VALUE_W'(DEC_BASE));
         mag               = mag / VALUE_W'(DEC_BASE);
         count++;
      end while (mag != '0 && count < DIGITS);
      if (neg) begin
         ch.code = CHAR_MINUS;
         ch.last = 1'b0;
         expected_text.push_back(ch);
         negative_words++;
      end
      for (int i = count - 1; i >= 0; i--) begin
         ch.code = CHAR_ZERO + CHAR_W'(digit_list[i]);
         ch.last = (i == 0);
         expected_text.push_back(ch);
      end
      if (count + int'(neg) == DIGITS + 1) begin
         full_length_words++;
      end
   endfunction

   // random word: full-range noise, chosen digit counts, all-nines and powers of ten, extremes
   function automatic logic [VALUE_W-1:0] pick_value();
      longint unsigned span;
      longint unsigned mag;
      longint unsigned limit;
      int              ndig;
      logic            neg;
      neg = 1'($urandom_range(1));
      case ($urandom_range(9))
         0, 1, 2, 3: return VALUE_W'($urandom);
         8: begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return MOST_NEG;
               2:       return MOST_POS;
               default: return neg ? '1 : VALUE_W'(1);
            endcase
         end
         default: begin
            ndig = $urandom_range(1, DIGITS);
            span = 1;
            repeat (ndig) span = span * DEC_BASE;
            if ($urandom_range(3) == 0) begin
               mag = $urandom_range(1) ? span - 1 : span / DEC_BASE;
            end else begin
               mag = {$urandom, $urandom} % span;
            end
            // clamp ten-digit magnitudes into range, which also lands on the extremes
            limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (mag > limit) begin
               mag = limit;
            end
            return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
         end
      endcase
   endfunction

   // one line per mismatch, printing capped so a broken block cannot flood the log
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
   endtask

   // offer one word, hold it until taken, then maybe idle a few cycles
   // start stays high after a take with no idle so the next word follows back to back
   task automatic send_word(input logic [VALUE_W-1:0] v);
      req_value <= v;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      spell_decimal(v);
      words_sent++;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // sender pauses until every owed character has come back
   task automatic drain_text();
      start <= 1'b0;
      do @(posedge clock); while (expected_text.size() != 0);
   endtask

   // checker and watchdog: sample at the edge that accepts a character
   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("character 0x%0h last %0b with none expected",
                                         rsp_character, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.code) begin
                  report_mismatch($sformatf("character 0x%0h, expected 0x%0h",
                                            rsp_character, want.code));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last %0b on character 0x%0h, expected %0b",
                                            rsp_last, want.code, want.last));
               end
            end
         end
         // any handshake on either side counts as progress
         if (rsp_strobe || (start && !busy)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("%0t ns: no progress for %0d cycles, %0d characters still owed",
                        $time, STALL_LIMIT, expected_text.size());
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   // corner words: zero, unit values, digit-count boundaries, both extremes, bit patterns
   task automatic test_corner_words();
      int corner_values[18] = '{0, 1, -1, 9, -9, 10, 99, 100, 2147483647, -2147483647,
                                1000000000, 999999999, -1000000000, 123456789, -987654321,
                                32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE};
      idle_pct = 0;
      send_word(MOST_NEG);
      foreach (corner_values[i]) begin
         send_word(VALUE_W'(corner_values[i]));
      end
      drain_text();
   endtask

   // random words offered every cycle, so busy has to push back
   task automatic test_back_to_back();
      idle_pct = 0;
      repeat (RANDOM_WORDS) send_word(pick_value());
      drain_text();
   endtask

   // sender idle more than half the time, gaps land on every phase of a text
   task automatic test_sparse_sender();
      idle_pct = 54;
      repeat (RANDOM_WORDS) send_word(pick_value());
      drain_text();
   endtask

   // occasional gaps inside otherwise dense traffic
   task automatic test_light_gaps();
      idle_pct = 6;
      repeat (RANDOM_WORDS) send_word(pick_value());
      drain_text();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_words();
      test_back_to_back();
      test_sparse_sender();
      test_light_gaps();

      // anything arriving now is an extra character
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d words (%0d negative, %0d of eleven characters), %0d characters",
               words_sent, negative_words, full_length_words, chars_checked);
      $display("traffic ran back to back, with a sparse sender and with light gaps");
      if (error_count == 0 && expected_text.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d characters never arrived", error_count,
                  expected_text.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
